### rtl/bgns_pkg.sv
`timescale 1ns / 1ps

package bgns_pkg;

    // Stream and register field widths
    localparam int DATA_W    = 64;
    localparam int COL_CFG_W = 7;
    localparam int ROW_CFG_W = 16;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;

    // Smallest grid that still has an interior
    localparam int MIN_COLS = 3;
    localparam int MIN_ROWS = 3;

    // Neighbour count at which a cell keeps its old value
    localparam int KEEP_COUNT = 3;

    // Register index, taken from paddr[2]
    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } t_reg_idx;

    // Control that travels with a queued row job
    typedef struct packed {
        logic smooth;   // smooth the middle row, else pass it unchanged
        logic last;     // the lower row closes the frame and goes out after it
    } t_job_ctl;

    localparam int JOB_CTL_W = $bits(t_job_ctl);

endpackage

### rtl/binary_grid_neighbor_smoothing.sv
`timescale 1ns / 1ps

// One pass of 3x3 binary cellular-automaton smoothing over a grid streamed one
// row per item. Interior cells with fewer than three open neighbours close, more
// than three open, exactly three keep their value; border rows and columns pass
// unchanged and unused columns read as zero. Results lag input by one row: the
// first row of a frame gives nothing, and the row that closes the frame gives
// two results (the smoothed row above it, then itself with tlast). A new row is
// taken every cycle while the job queue is not full; the output port gives one
// result per cycle while m_axis_tready is high, so the extra result at each
// frame end takes an output slot of its own. When the row that completes a
// result is accepted, its job enters the two-entry queue between the row buffer
// and the smoothing stage, then moves into the output register once that is
// free; the closing row waits in a pending register and follows it. Columns and
// rows per frame are set through the APB registers at addresses 0 and 4.
module binary_grid_neighbor_smoothing #(
    parameter int ROW_CELLS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bgns_pkg::DATA_W-1:0]       s_axis_tdata,  // [63:0] row_cells
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bgns_pkg::DATA_W-1:0]       m_axis_tdata,  // [63:0] smoothed_row
    output logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bgns_pkg::APB_AW-1:0]       paddr,
    input  logic [bgns_pkg::APB_DW-1:0]       pwdata,
    output logic [bgns_pkg::APB_DW-1:0]       prdata,
    output logic                              pready
);

    localparam int CW    = $clog2(ROW_CELLS + 1);
    localparam int JOB_W = 3 * ROW_CELLS + CW + bgns_pkg::JOB_CTL_W;

    logic [bgns_pkg::COL_CFG_W-1:0] r_cfg_cols;
    logic [bgns_pkg::ROW_CFG_W-1:0] r_cfg_rows;
    logic                           cfg_wr;
    bgns_pkg::t_reg_idx             reg_idx;

    logic                  in_accept;
    logic                  push;
    logic [ROW_CELLS-1:0]  f_up;
    logic [ROW_CELLS-1:0]  f_mid;
    logic [ROW_CELLS-1:0]  f_down;
    logic [CW-1:0]         f_cols;
    bgns_pkg::t_job_ctl    f_ctl;
    logic                  q_full;
    logic                  q_valid;
    logic                  q_pop;
    logic [JOB_W-1:0]      q_head;
    logic [ROW_CELLS-1:0]  b_up;
    logic [ROW_CELLS-1:0]  b_mid;
    logic [ROW_CELLS-1:0]  b_down;
    logic [CW-1:0]         b_cols;
    bgns_pkg::t_job_ctl    b_ctl;
    logic [ROW_CELLS-1:0]  out_row;

    // Configuration registers
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = bgns_pkg::t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= bgns_pkg::COL_CFG_W'(64);
            r_cfg_rows <= bgns_pkg::ROW_CFG_W'(64);
        end else if (cfg_wr) begin
            unique case (reg_idx)
                bgns_pkg::REG_COLUMNS: r_cfg_cols <= pwdata[bgns_pkg::COL_CFG_W-1:0];
                bgns_pkg::REG_ROWS:    r_cfg_rows <= pwdata[bgns_pkg::ROW_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            bgns_pkg::REG_COLUMNS: prdata = bgns_pkg::APB_DW'(r_cfg_cols);
            bgns_pkg::REG_ROWS:    prdata = bgns_pkg::APB_DW'(r_cfg_rows);
            default:               prdata = '0;
        endcase
    end

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    bgns_front #(
        .ROW_CELLS (ROW_CELLS),
        .CW        (CW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_accept),
        .i_row      (s_axis_tdata),
        .i_cfg_cols (r_cfg_cols),
        .i_cfg_rows (r_cfg_rows),
        .o_push     (push),
        .o_up       (f_up),
        .o_mid      (f_mid),
        .o_down     (f_down),
        .o_cols     (f_cols),
        .o_ctl      (f_ctl)
    );

    bgns_queue #(
        .W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_ctl, f_cols, f_down, f_mid, f_up}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_head)
    );

    assign {b_ctl, b_cols, b_down, b_mid, b_up} = q_head;

    bgns_back #(
        .ROW_CELLS (ROW_CELLS),
        .CW        (CW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .o_pop    (q_pop),
        .i_up     (b_up),
        .i_mid    (b_mid),
        .i_down   (b_down),
        .i_cols   (b_cols),
        .i_ctl    (b_ctl),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (out_row),
        .o_tlast  (m_axis_tlast)
    );

    assign m_axis_tdata = bgns_pkg::DATA_W'(out_row);

endmodule

### rtl/bgns_front.sv
`timescale 1ns / 1ps

module bgns_front #(
    parameter int ROW_CELLS = 64,
    parameter int CW        = $clog2(ROW_CELLS + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [bgns_pkg::DATA_W-1:0]      i_row,
    input  logic [bgns_pkg::COL_CFG_W-1:0]   i_cfg_cols,
    input  logic [bgns_pkg::ROW_CFG_W-1:0]   i_cfg_rows,
    output logic                             o_push,
    output logic [ROW_CELLS-1:0]             o_up,
    output logic [ROW_CELLS-1:0]             o_mid,
    output logic [ROW_CELLS-1:0]             o_down,
    output logic [CW-1:0]                    o_cols,
    output bgns_pkg::t_job_ctl               o_ctl
);

    logic [ROW_CELLS-1:0]               r_older;
    logic [ROW_CELLS-1:0]               r_newer;
    logic [bgns_pkg::ROW_CFG_W-1:0]     r_count;
    logic [ROW_CELLS-1:0]               n_older;
    logic [ROW_CELLS-1:0]               n_newer;
    logic [bgns_pkg::ROW_CFG_W-1:0]     n_count;

    logic [CW-1:0]                      cols;
    logic [bgns_pkg::ROW_CFG_W-1:0]     rows;
    logic [ROW_CELLS-1:0]               mask;
    logic [ROW_CELLS-1:0]               cur;
    logic                               have_prev;
    logic                               have_two;
    logic                               complete;

    // Clamp the column count to the range the hardware holds
    always_comb begin
        if (int'(i_cfg_cols) < bgns_pkg::MIN_COLS) begin
            cols = CW'(bgns_pkg::MIN_COLS);
        end else if (int'(i_cfg_cols) > ROW_CELLS) begin
            cols = CW'(ROW_CELLS);
        end else begin
            cols = CW'(i_cfg_cols);
        end
    end

    assign rows = (int'(i_cfg_rows) < bgns_pkg::MIN_ROWS)
                ? bgns_pkg::ROW_CFG_W'(bgns_pkg::MIN_ROWS) : i_cfg_rows;

    for (genvar j = 0; j < ROW_CELLS; j++) begin : g_mask
        assign mask[j] = (int'(cols) > j);
    end

    assign cur       = i_row[ROW_CELLS-1:0] & mask;
    assign have_prev = (r_count != '0);
    assign have_two  = (r_count > bgns_pkg::ROW_CFG_W'(1));
    assign complete  = have_two
                     && (({1'b0, r_count} + (bgns_pkg::ROW_CFG_W+1)'(1)) >= {1'b0, rows});

    assign o_push       = i_accept && have_prev;
    assign o_up         = r_older & mask;
    assign o_mid        = r_newer & mask;
    assign o_down       = cur;
    assign o_cols       = cols;
    assign o_ctl.smooth = have_two;
    assign o_ctl.last   = complete;

    always_comb begin
        n_older = r_older;
        n_newer = r_newer;
        n_count = r_count;
        if (i_accept) begin
            if (complete) begin
                // restart the frame
                n_older = '0;
                n_newer = '0;
                n_count = '0;
            end else begin
                n_older = r_newer;
                n_newer = cur;
                n_count = r_count + bgns_pkg::ROW_CFG_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_older <= n_older;
        r_newer <= n_newer;
    end

endmodule

### rtl/bgns_queue.sv
`timescale 1ns / 1ps

module bgns_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wptr;
    logic         r_rptr;
    logic [1:0]   r_cnt;
    logic         n_wptr;
    logic         n_rptr;
    logic [1:0]   n_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr = do_push ? ~r_wptr : r_wptr;
        n_rptr = do_pop ? ~r_rptr : r_rptr;
        n_cnt  = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

### rtl/bgns_back.sv
`timescale 1ns / 1ps

module bgns_back #(
    parameter int ROW_CELLS = 64,
    parameter int CW        = $clog2(ROW_CELLS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_pop,
    input  logic [ROW_CELLS-1:0]  i_up,
    input  logic [ROW_CELLS-1:0]  i_mid,
    input  logic [ROW_CELLS-1:0]  i_down,
    input  logic [CW-1:0]         i_cols,
    input  bgns_pkg::t_job_ctl    i_ctl,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [ROW_CELLS-1:0]  o_tdata,
    output logic                  o_tlast
);

    logic [ROW_CELLS-1:0] smoothed;
    logic [ROW_CELLS-1:0] result;

    logic                 r_out_valid;
    logic [ROW_CELLS-1:0] r_out_data;
    logic                 r_out_last;
    logic                 r_pend_valid;
    logic [ROW_CELLS-1:0] r_pend_data;
    logic                 n_out_valid;
    logic [ROW_CELLS-1:0] n_out_data;
    logic                 n_out_last;
    logic                 n_pend_valid;
    logic [ROW_CELLS-1:0] n_pend_data;

    logic                 out_free;

    // Edge columns keep their value
    assign smoothed[0]           = i_mid[0];
    assign smoothed[ROW_CELLS-1] = i_mid[ROW_CELLS-1];

    for (genvar j = 1; j < ROW_CELLS - 1; j++) begin : g_cell
        logic [3:0] nsum;
        logic       interior;
        assign nsum = 4'(i_up[j-1]) + 4'(i_up[j]) + 4'(i_up[j+1])
                    + 4'(i_mid[j-1]) + 4'(i_mid[j+1])
                    + 4'(i_down[j-1]) + 4'(i_down[j]) + 4'(i_down[j+1]);
        assign interior = (int'(i_cols) > j + 1);
        always_comb begin
            if (!interior) begin
                smoothed[j] = i_mid[j];
            end else if (nsum > 4'(bgns_pkg::KEEP_COUNT)) begin
                smoothed[j] = 1'b1;
            end else if (nsum < 4'(bgns_pkg::KEEP_COUNT)) begin
                smoothed[j] = 1'b0;
            end else begin
                smoothed[j] = i_mid[j];
            end
        end
    end

    assign result   = i_ctl.smooth ? smoothed : i_mid;
    assign out_free = !r_out_valid || i_tready;
    // hold new jobs while the closing row still waits
    assign o_pop    = i_valid && out_free && !r_pend_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        n_pend_valid = r_pend_valid;
        n_pend_data  = r_pend_data;
        priority if (o_pop) begin
            n_out_valid  = 1'b1;
            n_out_data   = result;
            n_out_last   = 1'b0;
            n_pend_valid = i_ctl.last;
            n_pend_data  = i_down;
        end else if (r_pend_valid && out_free) begin
            n_out_valid  = 1'b1;
            n_out_data   = r_pend_data;
            n_out_last   = 1'b1;
            n_pend_valid = 1'b0;
        end else if (i_tready) begin
            n_out_valid  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_out_last  <= n_out_last;
        r_pend_data <= n_pend_data;
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tlast  = r_out_last;

endmodule

### rtl/bgns_checker.sv
`timescale 1ns / 1ps

module bgns_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [bgns_pkg::DATA_W-1:0]       m_axis_tdata,
    input  logic                              m_axis_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bgns_pkg::APB_AW-1:0]       paddr,
    input  logic [bgns_pkg::APB_DW-1:0]       pwdata,
    input  logic                              pready
);

    logic [bgns_pkg::COL_CFG_W-1:0] r_cols;
    logic [bgns_pkg::DATA_W-1:0]    used_mask;
    logic [bgns_pkg::COL_CFG_W-1:0] eff_cols;

    // Mirror the column register from the bus
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= bgns_pkg::COL_CFG_W'(64);
        end else if (psel && penable && pwrite && pready
                     && bgns_pkg::t_reg_idx'(paddr[2]) == bgns_pkg::REG_COLUMNS) begin
            r_cols <= pwdata[bgns_pkg::COL_CFG_W-1:0];
        end
    end

    assign eff_cols  = (int'(r_cols) < bgns_pkg::MIN_COLS)
                     ? bgns_pkg::COL_CFG_W'(bgns_pkg::MIN_COLS) : r_cols;
    assign used_mask = (int'(eff_cols) >= bgns_pkg::DATA_W) ? '1
                     : ((bgns_pkg::DATA_W'(1) << eff_cols) - bgns_pkg::DATA_W'(1));

    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata & ~used_mask) == '0))
        else $error("bits beyond used columns not zero");

    a_frame_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
            !(m_axis_tvalid && m_axis_tlast))
        else $error("frame end follows frame end");

endmodule

bind binary_grid_neighbor_smoothing bgns_checker u_bgns_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready)
);

### dv/binary_grid_neighbor_smoothing_test.sv
`timescale 1ns / 1ps

module binary_grid_neighbor_smoothing_test;

    localparam int HOLD_CYCLES = 250;
    localparam int ROW_TARGET  = 1350;

    typedef struct packed {
        logic [bgns_pkg::DATA_W-1:0] row;
        logic                        last;
    } t_smoothed;

    class row_scoreboard;
        logic [bgns_pkg::COL_CFG_W-1:0] cols_reg;
        logic [bgns_pkg::ROW_CFG_W-1:0] rows_reg;
        logic [bgns_pkg::DATA_W-1:0]    older;
        logic [bgns_pkg::DATA_W-1:0]    newer;
        int unsigned                    rows_seen;
        t_smoothed                      expected_rows[$];
        int unsigned                    rows_noted;
        int unsigned                    results_checked;
        int unsigned                    frames_closed;
        int unsigned                    errors;

        function new();
            cols_reg        = 7'd64;
            rows_reg        = 16'd64;
            older           = '0;
            newer           = '0;
            rows_seen       = 0;
            rows_noted      = 0;
            results_checked = 0;
            frames_closed   = 0;
            errors          = 0;
        endfunction

        function void write_reg(bgns_pkg::t_reg_idx idx, logic [bgns_pkg::APB_DW-1:0] value);
            if (idx == bgns_pkg::REG_COLUMNS)
                cols_reg = value[bgns_pkg::COL_CFG_W-1:0];
            else
                rows_reg = value[bgns_pkg::ROW_CFG_W-1:0];
        endfunction

        function int unsigned used_cols();
            int unsigned c;
            c = cols_reg;
            if (c < bgns_pkg::MIN_COLS) c = bgns_pkg::MIN_COLS;
            if (c > bgns_pkg::DATA_W) c = bgns_pkg::DATA_W;
            return c;
        endfunction

        function logic [bgns_pkg::DATA_W-1:0] smooth_middle(
                logic [bgns_pkg::DATA_W-1:0] up, logic [bgns_pkg::DATA_W-1:0] mid,
                logic [bgns_pkg::DATA_W-1:0] dn, int unsigned ncols);
            logic [bgns_pkg::DATA_W-1:0] res;
            int                          n;
            res = mid;
            for (int j = 1; j + 1 < ncols; j++) begin
                n = int'(up[j-1]) + int'(up[j]) + int'(up[j+1])
                  + int'(mid[j-1]) + int'(mid[j+1])
                  + int'(dn[j-1]) + int'(dn[j]) + int'(dn[j+1]);
                if (n < bgns_pkg::KEEP_COUNT)
                    res[j] = 1'b0;
                else if (n > bgns_pkg::KEEP_COUNT)
                    res[j] = 1'b1;
            end
            return res;
        endfunction

        function void note_row(logic [bgns_pkg::DATA_W-1:0] din);
            int unsigned                 ncols;
            int unsigned                 nrows;
            logic [bgns_pkg::DATA_W-1:0] mask;
            logic [bgns_pkg::DATA_W-1:0] cur;
            logic [bgns_pkg::DATA_W-1:0] prev;
            ncols = used_cols();
            mask  = (ncols >= bgns_pkg::DATA_W) ? '1 : ((64'd1 << ncols) - 64'd1);
            cur   = din & mask;
            nrows = (rows_reg < bgns_pkg::MIN_ROWS) ? bgns_pkg::MIN_ROWS : rows_reg;
            rows_noted++;
            if (rows_seen >= 1) begin
                prev = newer & mask;
                if (rows_seen >= 2)
                    prev = smooth_middle(older & mask, prev, cur, ncols) & mask;
                expected_rows.push_back('{row: prev, last: 1'b0});
            end
            // the closing row also flushes itself, then the frame starts over
            if (rows_seen >= 2 && rows_seen + 1 >= nrows) begin
                expected_rows.push_back('{row: cur, last: 1'b1});
                older     = '0;
                newer     = '0;
                rows_seen = 0;
                frames_closed++;
                return;
            end
            older     = newer;
            newer     = cur;
            rows_seen = (rows_seen + 1) & 16'hFFFF;
        endfunction

        function void check_result(logic [bgns_pkg::DATA_W-1:0] row, logic last);
            t_smoothed exp_item;
            if (expected_rows.size() == 0) begin
                $error("unexpected item: smoothed_row=%h last_row=%b", row, last);
                errors++;
                return;
            end
            exp_item = expected_rows.pop_front();
            results_checked++;
            if (row !== exp_item.row) begin
                $error("smoothed_row: expected %h, got %h", exp_item.row, row);
                errors++;
            end
            if (last !== exp_item.last) begin
                $error("last_row: expected %b, got %b", exp_item.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [bgns_pkg::DATA_W-1:0]   s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [bgns_pkg::DATA_W-1:0]   m_axis_tdata;
    logic                          m_axis_tlast;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [bgns_pkg::APB_AW-1:0]   paddr = '0;
    logic [bgns_pkg::APB_DW-1:0]   pwdata = '0;
    logic [bgns_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    row_scoreboard       sb = new();
    int unsigned         rows_sent = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int unsigned         hold_req = 0;
    int unsigned         hold_ack = 0;
    int                  hold_left = 0;

    binary_grid_neighbor_smoothing #(.ROW_CELLS(bgns_pkg::DATA_W)) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [63:0] row_cells
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [63:0] smoothed_row
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #6 i_clk = ~i_clk;

    // Receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            m_axis_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_ack <= hold_req;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_row(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    task automatic write_reg(bgns_pkg::t_reg_idx idx, int unsigned value);
        logic [bgns_pkg::APB_DW-1:0] word;
        word = $urandom;
        if (idx == bgns_pkg::REG_COLUMNS)
            word[bgns_pkg::COL_CFG_W-1:0] = value[bgns_pkg::COL_CFG_W-1:0];
        else
            word[bgns_pkg::ROW_CFG_W-1:0] = value[bgns_pkg::ROW_CFG_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.write_reg(idx, word);
    endtask

    task automatic set_grid(int unsigned cols, int unsigned rows);
        write_reg(bgns_pkg::REG_COLUMNS, cols);
        write_reg(bgns_pkg::REG_ROWS, rows);
    endtask

    task automatic send_row(logic [bgns_pkg::DATA_W-1:0] row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= row;
        do @(posedge i_clk); while (!s_axis_tready);
        rows_sent++;
    endtask

    // Drop valid and wait until every row is in and every result is out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk);
        while (sb.rows_noted != rows_sent || sb.expected_rows.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    function automatic logic [bgns_pkg::DATA_W-1:0] random_row();
        logic [bgns_pkg::DATA_W-1:0] a;
        logic [bgns_pkg::DATA_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            5, 6:    return a & b;
            7, 8:    return a | b;
            9:       return $urandom_range(0, 1) ? '1 : '0;
            default: return a;
        endcase
    endfunction

    function automatic int unsigned used_rows(int unsigned rows);
        return (rows < bgns_pkg::MIN_ROWS) ? bgns_pkg::MIN_ROWS : rows;
    endfunction

    // Send rows until the frame closes, given the rows already in this frame
    task automatic finish_frame(int unsigned already, int unsigned nrows);
        int unsigned r;
        bit          closing;
        r = already;
        closing = 1'b0;
        while (!closing) begin
            closing = (r >= 2 && r + 1 >= nrows);
            send_row(random_row());
            r++;
        end
    endtask

    function automatic int unsigned pick_cols();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(0, 2);
            1:       return $urandom_range(65, 127);
            2, 3:    return 64;
            4:       return 3;
            default: return $urandom_range(4, 63);
        endcase
    endfunction

    function automatic int unsigned pick_rows();
        case ($urandom_range(0, 19))
            0:       return $urandom_range(0, 2);
            1, 2:    return $urandom_range(20, 48);
            default: return $urandom_range(3, 10);
        endcase
    endfunction

    task automatic random_frame();
        int unsigned rows;
        int unsigned sent;
        int unsigned shrunk;
        if ($urandom_range(0, 9) == 0) begin
            // cut the frame short part way through
            set_grid(pick_cols(), $urandom_range(0, 1) ? 65535 : $urandom_range(12, 4000));
            sent = $urandom_range(1, 6);
            repeat (sent) send_row(random_row());
            wait_idle();
            shrunk = $urandom_range(0, sent + 2);
            set_grid(pick_cols(), shrunk);
            finish_frame(sent, used_rows(shrunk));
        end else begin
            rows = pick_rows();
            set_grid(pick_cols(), rows);
            finish_frame(0, used_rows(rows));
        end
        wait_idle();
    endtask

    initial begin
        int unsigned frame_no;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full width, smallest frame, solid and striped rows
        set_grid(64, 3);
        send_row('1);
        send_row('0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA);
        send_row(64'h5555_5555_5555_5555);
        send_row('1);
        send_row('0);
        wait_idle();
        // narrowest grid, junk above the used width
        set_grid(3, 0);
        repeat (3) send_row(random_row() | 64'hFFFF_0000_0000_0000);
        wait_idle();
        set_grid(127, 2);
        send_row(64'h8000_0000_0000_0001);
        send_row('1);
        send_row(64'h0123_4567_89AB_CDEF);
        wait_idle();
        set_grid(0, 1);
        repeat (3) send_row(random_row());
        wait_idle();
        // largest frame, then shrink it below the rows already taken
        set_grid(65, 65535);
        repeat (5) send_row(random_row());
        wait_idle();
        write_reg(bgns_pkg::REG_ROWS, 4);
        send_row(random_row());
        wait_idle();

        frame_no = 0;
        while (rows_sent < ROW_TARGET) begin
            case ((frame_no / 6) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            if (frame_no == 30) begin
                // long receiver hold-off while rows keep coming
                send_idle_pct = 0;
                set_grid(pick_cols(), 40);
                hold_req <= hold_req + 1;
                finish_frame(0, 40);
                wait_idle();
            end else begin
                random_frame();
            end
            frame_no++;
        end

        wait_idle();
        $display("Sent %0d rows over %0d closed frames; checked %0d smoothed rows.",
                 rows_sent, sb.frames_closed, sb.results_checked);
        $display("Covered widths 3..64 with clamping, short and cut-short frames, stalls.");
        if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
